@@ rtl/core/cave_pkg.sv @@
// Shared types and constants for the cave cellular automaton unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package cave_pkg;

  // Grid geometry. The row word is fixed at 64 cells; the store holds 2**ROW_AW rows.
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned ROW_AW    = 6;
  localparam int unsigned MAX_ROWS  = 1 << ROW_AW;
  localparam int unsigned MAX_WIDTH = 64;

  // Configuration register fields.
  localparam int unsigned DIM_W  = 7;
  localparam int unsigned GEN_W  = 8;
  localparam int unsigned THR_W  = 4;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 8;
  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_GEN_COUNT   = 3'd2,
    REG_SURVIVE     = 3'd3,
    REG_BIRTH       = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_FIRST,
    ST_ROW,
    ST_DONE
  } state_e;

  // Rule settings handed to the row update unit.
  typedef struct packed {
    logic [ROW_W-1:0] width_mask;
    logic [THR_W-1:0] survive;
    logic [THR_W-1:0] birth;
  } rule_t;

endpackage

@@ rtl/core/cave_if.sv @@
// Channel interfaces of the cave cellular automaton unit: item in, result out, config write.
// Depends on cave_pkg for field widths.
interface cave_in_if;
  logic                          valid;
  logic                          ready;
  logic [cave_pkg::MODE_W-1:0]   mode;
  logic [cave_pkg::ROW_AW-1:0]   row_index;
  logic [cave_pkg::ROW_W-1:0]    row_bits;

  modport source (output valid, output mode, output row_index, output row_bits, input ready);
  modport sink   (input valid, input mode, input row_index, input row_bits, output ready);
endinterface

interface cave_out_if;
  logic                          valid;
  logic                          ready;
  logic [cave_pkg::ROW_W-1:0]    read_bits;
  logic [cave_pkg::MODE_W-1:0]   done_mode;

  modport source (output valid, output read_bits, output done_mode, input ready);
  modport sink   (input valid, input read_bits, input done_mode, output ready);
endinterface

interface cave_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cave_pkg::CFG_AW-1:0]   index;
  logic [cave_pkg::CFG_DW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/cave_row_update.sv @@
// Row update unit: next state of one grid row from the old rows above, at and below it.
// Depends on cave_pkg for the row width and the rule_t struct.
module cave_row_update (
  input  logic [cave_pkg::ROW_W-1:0] up_i,
  input  logic [cave_pkg::ROW_W-1:0] cur_i,
  input  logic [cave_pkg::ROW_W-1:0] down_i,
  input  cave_pkg::rule_t            rule_i,
  output logic [cave_pkg::ROW_W-1:0] next_o
);

  // Inputs arrive masked to the width, so cells past either edge read as empty.
  logic [cave_pkg::ROW_W-1:0] up_l, up_r, cur_l, cur_r, dn_l, dn_r;

  assign up_l  = up_i << 1;
  assign up_r  = up_i >> 1;
  assign cur_l = cur_i << 1;
  assign cur_r = cur_i >> 1;
  assign dn_l  = down_i << 1;
  assign dn_r  = down_i >> 1;

  always_comb begin
    logic [3:0] n;
    logic       alive;
    next_o = '0;
    for (int x = 0; x < cave_pkg::ROW_W; x++) begin
      n = 4'(up_i[x]) + 4'(down_i[x]) + 4'(up_l[x]) + 4'(cur_l[x]) + 4'(dn_l[x])
        + 4'(up_r[x]) + 4'(cur_r[x]) + 4'(dn_r[x]);
      alive = cur_i[x] ? (n >= rule_i.survive) : (n >= rule_i.birth);
      next_o[x] = alive & rule_i.width_mask[x];
    end
  end

endmodule

@@ rtl/core/cave_cellular_automaton_unit.sv @@
// Top level of the cave cellular automaton: grid store, sequencer, config registers.
// Depends on cave_pkg, the interfaces in cave_if.sv and cave_row_update.
//
//   channel | dir | words                              | accepted when
//   --------+-----+------------------------------------+----------------------
//   in_i    | in  | mode, row_index, row_bits          | in_i.valid & in_i.ready
//   out_o   | out | read_bits, done_mode               | out_o.valid & out_o.ready
//   cfg_i   | in  | index, data                        | cfg_i.valid & cfg_i.ready
//
// A load word passes through ST_DONE, and a read word through ST_READ and ST_DONE, before
// the unit is ready again. A run word goes straight to ST_DONE if it has no generations or
// the height in use is zero; else each generation re-reads row 0 and then rewrites one row
// per cycle through the single row update unit, fed by the one read port of the store.
// Reset clears the per-row valid bits at once, so the whole grid reads empty with no
// clearing pass. The result register lets a new word be taken while the previous
// result waits; a word finishing while that register is still full waits for it.
module cave_cellular_automaton_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cave_in_if.sink     in_i,
  cave_out_if.source  out_o,
  cave_cfg_if.sink    cfg_i
);

  localparam int unsigned RW = cave_pkg::ROW_W;
  localparam int unsigned AW = cave_pkg::ROW_AW;
  localparam int unsigned DW = cave_pkg::DIM_W;

  // Configuration registers.
  logic [DW-1:0]                  grid_width_q, grid_height_q;
  logic [cave_pkg::GEN_W-1:0]     gen_count_q;
  logic [cave_pkg::THR_W-1:0]     survive_q, birth_q;

  // Sequencer state.
  cave_pkg::state_e               state_q, state_d;
  logic [AW-1:0]                  y_q, y_d;
  logic [cave_pkg::GEN_W-1:0]     gen_left_q, gen_left_d;
  logic [RW-1:0]                  up_q, up_d, cur_q, cur_d;
  logic                           down_ok_q, down_ok_d;
  logic [cave_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [RW-1:0]                  item_bits_q, item_bits_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  logic [RW-1:0]                  out_bits_q, out_bits_d;
  logic [cave_pkg::MODE_W-1:0]    out_mode_q, out_mode_d;

  // Grid store: one write port and one registered read port. A row never written
  // since reset has its valid bit low and reads as all empty.
  logic [RW-1:0]                  mem [cave_pkg::MAX_ROWS];
  logic [cave_pkg::MAX_ROWS-1:0]  row_valid_q;
  logic [RW-1:0]                  rd_data_q;
  logic                           rd_hit_q;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic [RW-1:0]                  mem_wdata;

  // Derived geometry and rule.
  logic [DW-1:0]                  eff_w, eff_h;
  logic [RW-1:0]                  width_mask;
  logic [RW-1:0]                  rd_row, down_row, next_row;
  logic [DW-1:0]                  y_ext, y_plus2;
  logic                           last_row;
  cave_pkg::rule_t                rule;
  logic                           in_fire;

  assign eff_w = (grid_width_q > DW'(cave_pkg::MAX_WIDTH)) ? DW'(cave_pkg::MAX_WIDTH)
                                                            : grid_width_q;
  assign eff_h = (grid_height_q > DW'(cave_pkg::MAX_ROWS)) ? DW'(cave_pkg::MAX_ROWS)
                                                            : grid_height_q;
  // A width of 64 or more keeps every bit; below that the mask is a run of ones.
  assign width_mask = (eff_w >= DW'(RW)) ? '1 : ((RW'(1) << eff_w) - RW'(1));

  assign rule = '{width_mask: width_mask, survive: survive_q, birth: birth_q};

  assign rd_row   = rd_hit_q ? rd_data_q : '0;
  assign down_row = down_ok_q ? (rd_row & width_mask) : '0;
  assign y_ext    = DW'(y_q);
  assign y_plus2  = y_ext + DW'(2);
  assign last_row = (y_ext == (eff_h - DW'(1)));

  assign in_i.ready  = (state_q == cave_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.read_bits = out_bits_q;
  assign out_o.done_mode = out_mode_q;

  cave_row_update u_row_update (
    .up_i   (up_q),
    .cur_i  (cur_q),
    .down_i (down_row),
    .rule_i (rule),
    .next_o (next_row)
  );

  // Configuration writes; indexes past the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DW'(64);
      grid_height_q <= DW'(64);
      gen_count_q   <= cave_pkg::GEN_W'(4);
      survive_q     <= cave_pkg::THR_W'(4);
      birth_q       <= cave_pkg::THR_W'(5);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        cave_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_i.data[DW-1:0];
        cave_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_i.data[DW-1:0];
        cave_pkg::REG_GEN_COUNT:   gen_count_q   <= cfg_i.data[cave_pkg::GEN_W-1:0];
        cave_pkg::REG_SURVIVE:     survive_q     <= cfg_i.data[cave_pkg::THR_W-1:0];
        cave_pkg::REG_BIRTH:       birth_q       <= cfg_i.data[cave_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer. A run walks the rows top to bottom once per generation. The row at
  // the cursor and the one above it are kept aside in up_q and cur_q, so that the
  // rewrite of a row never disturbs what the next row still needs. The store read for
  // the row below is issued in the cycle before it is used, two rows past the cursor.
  always_comb begin
    state_d     = state_q;
    y_d         = y_q;
    gen_left_d  = gen_left_q;
    up_d        = up_q;
    cur_d       = cur_q;
    down_ok_d   = down_ok_q;
    mode_d      = mode_q;
    item_bits_d = item_bits_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_bits_d  = out_bits_q;
    out_mode_d  = out_mode_q;
    mem_we      = 1'b0;
    mem_waddr   = y_q;
    mem_wdata   = next_row;
    mem_raddr   = y_plus2[AW-1:0];

    unique case (state_q)
      cave_pkg::ST_IDLE: begin
        mem_raddr = in_i.row_index;
        if (in_fire) begin
          mode_d      = in_i.mode;
          item_bits_d = '0;
          unique case (in_i.mode)
            cave_pkg::MODE_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = in_i.row_index;
              mem_wdata = in_i.row_bits & width_mask;
              state_d   = cave_pkg::ST_DONE;
            end
            cave_pkg::MODE_RUN: begin
              gen_left_d = gen_count_q;
              // No generations or no rows in use: nothing changes.
              if (gen_count_q == '0 || eff_h == '0) begin
                state_d = cave_pkg::ST_DONE;
              end else begin
                state_d = cave_pkg::ST_GEN;
              end
            end
            cave_pkg::MODE_READ: begin
              state_d = cave_pkg::ST_READ;
            end
            default: ;  // The unused mode is swallowed without a result.
          endcase
        end
      end

      cave_pkg::ST_READ: begin
        item_bits_d = rd_row;
        state_d     = cave_pkg::ST_DONE;
      end

      cave_pkg::ST_GEN: begin
        mem_raddr = '0;
        y_d       = '0;
        state_d   = cave_pkg::ST_FIRST;
      end

      cave_pkg::ST_FIRST: begin
        up_d      = '0;
        cur_d     = rd_row & width_mask;
        mem_raddr = AW'(1);
        down_ok_d = (DW'(1) < eff_h);
        state_d   = cave_pkg::ST_ROW;
      end

      cave_pkg::ST_ROW: begin
        mem_we    = 1'b1;
        up_d      = cur_q;
        cur_d     = down_row;
        down_ok_d = (y_plus2 < eff_h);
        if (last_row) begin
          gen_left_d = gen_left_q - cave_pkg::GEN_W'(1);
          state_d    = (gen_left_q == cave_pkg::GEN_W'(1)) ? cave_pkg::ST_DONE
                                                           : cave_pkg::ST_GEN;
        end else begin
          y_d = y_q + AW'(1);
        end
      end

      cave_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_bits_d  = item_bits_q;
          out_mode_d  = mode_q;
          state_d     = cave_pkg::ST_IDLE;
        end
      end

      default: state_d = cave_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cave_pkg::ST_IDLE;
      gen_left_q  <= '0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_hit_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_left_q  <= gen_left_d;
      out_valid_q <= out_valid_d;
      rd_hit_q    <= row_valid_q[mem_raddr];
      if (mem_we) begin
        row_valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    up_q        <= up_d;
    cur_q       <= cur_d;
    down_ok_q   <= down_ok_d;
    mode_q      <= mode_d;
    item_bits_q <= item_bits_d;
    out_bits_q  <= out_bits_d;
    out_mode_q  <= out_mode_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  // Every word written to the store is clear at and above the width in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((mem_wdata & ~width_mask) == '0))
    else $error("grid row written with cells beyond the width");

  // The row cursor of a run stays inside the rows in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cave_pkg::ST_ROW) |-> (y_ext < eff_h))
    else $error("row cursor past the grid height");

  // While a run is active at least one generation is still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cave_pkg::ST_GEN || state_q == cave_pkg::ST_FIRST ||
     state_q == cave_pkg::ST_ROW) |-> (gen_left_q != '0))
    else $error("run active with no generations left");

  // A completed word is handed to the result register with its own mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cave_pkg::ST_DONE && (!out_valid_q || out_o.ready))
      |=> (out_valid_q && out_mode_q == $past(mode_q)))
    else $error("result lost or tagged with the wrong mode");

  // A read word holds in item_bits_q the row seen by the read port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cave_pkg::ST_READ) |=> (item_bits_q == $past(rd_row)))
    else $error("read result does not match the stored row");
`endif

endmodule
